/* rtl/core/timer_progress_monitor_unit_defines.svh */
// ----------------------------------------------------------------------------
// Timer progress monitor: assertion macros
// Shared macros for the concurrent checks on the monitor's ports.
// ----------------------------------------------------------------------------
`ifndef TIMER_PROGRESS_MONITOR_UNIT_DEFINES_SVH
`define TIMER_PROGRESS_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("timer progress monitor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("timer progress monitor check failed");

`endif

/* rtl/core/tpm_pkg.sv */
// ----------------------------------------------------------------------------
// Timer progress monitor package
// Types and constants shared by the monitor's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpm_pkg;

	localparam int unsigned ADDR_W = 6;
	localparam int unsigned DATA_W = 64;

	localparam logic [63:0] ALL_ONES_64 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ALL_ONES_32 = 64'h0000_0000_FFFF_FFFF;
	localparam logic [7:0]  RUN_MAX     = 8'hFF;

	localparam logic [7:0]  DEBOUNCE_RESET = 8'd25;
	localparam logic [31:0] STARTUP_RESET  = 32'd100;

	typedef enum logic [1:0] {
		HEALTH_START,
		HEALTH_OK,
		HEALTH_STUCK,
		HEALTH_DRIFT
	} health_t;

	typedef enum logic [2:0] {
		REG_MONITOR_ENABLE,
		REG_COUNTER_IS_WIDE,
		REG_LOWER_LIMIT,
		REG_UPPER_LIMIT,
		REG_DEBOUNCE_LIMIT,
		REG_STARTUP_WAIT,
		REG_REPORT_ENABLE
	} reg_index_t;

	typedef struct packed {
		logic        monitor_enable;
		logic        counter_is_wide;
		logic [63:0] lower_limit;
		logic [63:0] upper_limit;
		logic [7:0]  debounce_limit;
		logic [31:0] startup_wait;
		logic        report_enable;
	} tpm_cfg_t;

endpackage

/* rtl/core/timer_progress_monitor_unit.sv */
// ----------------------------------------------------------------------------
// Timer progress monitor
// Checks periodic samples of a free-running counter for stalls and drift.
// ----------------------------------------------------------------------------
// The monitor takes one counter sample per clock cycle while sample_stall is
// low and returns exactly one result for each sample; an accepted sample
// passes through the input register and then the result register. Throughput
// is set by the combinational delta, window compare and debounce update in
// tpm_core, which reads and writes the running state in the same cycle.
// A sample waits in the input register while a finished result is held
// under stall, so the input side keeps flowing until both stages are full.
// There is no clearing pass after reset. Configuration registers sit at byte
// address 8*i and should be written only while no sample is in flight.
`timescale 1ns / 1ps

module timer_progress_monitor_unit #(
	parameter int unsigned PERIOD_COUNT_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpm_pkg::ADDR_W-1:0]  paddr,
	input  logic [tpm_pkg::DATA_W-1:0]  pwdata,
	output logic [tpm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic [63:0]                 counter_value,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [1:0]                  health,
	output logic [63:0]                 elapsed,
	output logic                        checked,
	output logic                        fault_event
);
	import tpm_pkg::*;

	tpm_cfg_t    cfg;
	logic        valid_s1;
	logic [63:0] sample_s1;
	logic        result_valid_q;
	logic        advance;
	logic        step;

	assign pready = 1'b1;

	// The result register can take a new value when it is empty or drained.
	assign advance      = !result_valid_q || !result_stall;
	assign step         = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!sample_stall) valid_s1 <= sample_valid;
			if (advance) result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) sample_s1 <= counter_value;
	end

	tpm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tpm_core #(
		.PERIOD_COUNT_BITS (PERIOD_COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (step),
		.sample_s1   (sample_s1),
		.health      (health),
		.elapsed     (elapsed),
		.checked     (checked),
		.fault_event (fault_event)
	);

endmodule

/* rtl/core/tpm_regs.sv */
// ----------------------------------------------------------------------------
// Timer progress monitor register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpm_pkg::ADDR_W-1:0]  paddr,
	input  logic [tpm_pkg::DATA_W-1:0]  pwdata,
	output logic [tpm_pkg::DATA_W-1:0]  prdata,
	output tpm_pkg::tpm_cfg_t           cfg
);
	import tpm_pkg::*;

	reg_index_t idx;
	logic       wr_en;
	tpm_cfg_t   cfg_q;

	// Registers sit on 8-byte boundaries; the low address bits are ignored.
	assign idx   = reg_index_t'(paddr[ADDR_W-1:3]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.monitor_enable  <= 1'b1;
			cfg_q.counter_is_wide <= 1'b0;
			cfg_q.lower_limit     <= '0;
			cfg_q.upper_limit     <= ALL_ONES_64;
			cfg_q.debounce_limit  <= DEBOUNCE_RESET;
			cfg_q.startup_wait    <= STARTUP_RESET;
			cfg_q.report_enable   <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				REG_MONITOR_ENABLE:  cfg_q.monitor_enable  <= pwdata[0];
				REG_COUNTER_IS_WIDE: cfg_q.counter_is_wide <= pwdata[0];
				REG_LOWER_LIMIT:     cfg_q.lower_limit     <= pwdata;
				REG_UPPER_LIMIT:     cfg_q.upper_limit     <= pwdata;
				REG_DEBOUNCE_LIMIT:  cfg_q.debounce_limit  <= pwdata[7:0];
				REG_STARTUP_WAIT:    cfg_q.startup_wait    <= pwdata[31:0];
				REG_REPORT_ENABLE:   cfg_q.report_enable   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MONITOR_ENABLE:  prdata = {63'd0, cfg_q.monitor_enable};
			REG_COUNTER_IS_WIDE: prdata = {63'd0, cfg_q.counter_is_wide};
			REG_LOWER_LIMIT:     prdata = cfg_q.lower_limit;
			REG_UPPER_LIMIT:     prdata = cfg_q.upper_limit;
			REG_DEBOUNCE_LIMIT:  prdata = {56'd0, cfg_q.debounce_limit};
			REG_STARTUP_WAIT:    prdata = {32'd0, cfg_q.startup_wait};
			REG_REPORT_ENABLE:   prdata = {63'd0, cfg_q.report_enable};
			default:             prdata = '0;
		endcase
	end

endmodule

/* rtl/core/tpm_core.sv */
// ----------------------------------------------------------------------------
// Timer progress monitor core
// Per-sample state update and result register for one monitored counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpm_core #(
	parameter int unsigned PERIOD_COUNT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tpm_pkg::tpm_cfg_t cfg,
	input  logic              step,
	input  logic [63:0]       sample_s1,
	output logic [1:0]        health,
	output logic [63:0]       elapsed,
	output logic              checked,
	output logic              fault_event
);
	import tpm_pkg::*;

	localparam int unsigned PW = PERIOD_COUNT_BITS;
	localparam int unsigned CW = (PW > 32) ? PW : 32;

	logic [63:0]   prev_q;
	logic [PW-1:0] period_q;
	logic [7:0]    stuck_run_q;
	logic [7:0]    drift_run_q;
	health_t       health_q;
	logic [63:0]   last_delta_q;

	logic [CW-1:0] period_ext;
	logic [CW-1:0] wait_ext;
	logic          check_en;
	logic          same;
	logic          wrapped;
	logic [63:0]   diff;
	logic [63:0]   delta;
	logic          out_of_window;
	logic [7:0]    stuck_run_nx;
	logic [7:0]    drift_run_nx;
	health_t       health_nx;
	logic          event_nx;

	assign period_ext = CW'(period_q);
	assign wait_ext   = CW'(cfg.startup_wait);

	assign check_en = cfg.monitor_enable && (period_ext >= wait_ext) &&
		(health_q != HEALTH_STUCK) && (health_q != HEALTH_DRIFT);

	// A wrapped sample adds the all-ones value of the selected counter width,
	// which lands one count short of the true distance.
	assign same    = (sample_s1 == prev_q);
	assign wrapped = (sample_s1 < prev_q);
	assign diff    = sample_s1 - prev_q;
	assign delta   = wrapped ?
		diff + (cfg.counter_is_wide ? ALL_ONES_64 : ALL_ONES_32) : diff;

	assign out_of_window = (delta < cfg.lower_limit) || (delta > cfg.upper_limit);

	always_comb begin
		stuck_run_nx = stuck_run_q;
		drift_run_nx = drift_run_q;
		if (same) begin
			if (stuck_run_q != RUN_MAX) stuck_run_nx = stuck_run_q + 8'd1;
		end else if (out_of_window) begin
			if (drift_run_q != RUN_MAX) drift_run_nx = drift_run_q + 8'd1;
		end else begin
			stuck_run_nx = '0;
			drift_run_nx = '0;
		end

		if (stuck_run_nx >= cfg.debounce_limit) begin
			health_nx = HEALTH_STUCK;
		end else if (drift_run_nx >= cfg.debounce_limit) begin
			health_nx = HEALTH_DRIFT;
		end else begin
			health_nx = HEALTH_OK;
		end

		event_nx = cfg.report_enable &&
			((health_nx == HEALTH_STUCK) || (health_nx == HEALTH_DRIFT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			period_q     <= '0;
			stuck_run_q  <= '0;
			drift_run_q  <= '0;
			health_q     <= HEALTH_START;
			last_delta_q <= '0;
		end else if (step) begin
			// The period count runs on every sample, enabled or not, until it saturates.
			if (period_q != {PW{1'b1}}) period_q <= period_q + PW'(1);
			if (cfg.monitor_enable) prev_q <= sample_s1;
			if (check_en) begin
				stuck_run_q  <= stuck_run_nx;
				drift_run_q  <= drift_run_nx;
				health_q     <= health_nx;
				last_delta_q <= delta;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			health      <= check_en ? health_nx : health_q;
			elapsed     <= check_en ? delta : last_delta_q;
			checked     <= check_en;
			fault_event <= check_en && event_nx;
		end
	end

endmodule

/* rtl/core/tpm_checker.sv */
// ----------------------------------------------------------------------------
// Timer progress monitor checker
// Port-level checks on results, bound to the monitor's top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timer_progress_monitor_unit_defines.svh"

module tpm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic                        pready,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [1:0]                  health,
	input logic [63:0]                 elapsed,
	input logic                        checked,
	input logic                        fault_event
);
	import tpm_pkg::*;

	logic cfg_write;
	logic latched;

	assign cfg_write = psel && penable && pwrite && pready;
	assign latched   = (health == HEALTH_STUCK) || (health == HEALTH_DRIFT);

	// A fault event only comes from a sample that was checked and latched.
	`TPM_ASSERT_IMP(a_event_latches, clk, arst_n, result_valid && fault_event, checked && latched)

	// A checked sample always leaves the starting state behind.
	`TPM_ASSERT_IMP(a_checked_not_start, clk, arst_n, result_valid && checked, health != HEALTH_START)

	// Once latched, the health never changes and no further check runs.
	`TPM_ASSERT_NXT(a_latch_holds, clk, arst_n, result_valid && !result_stall && latched && !cfg_write, !result_valid || (health == $past(health) && !checked))

	// A stalled result keeps its payload.
	`TPM_ASSERT_NXT(a_stall_holds, clk, arst_n, result_valid && result_stall, result_valid && $stable(health) && $stable(elapsed) && $stable(checked) && $stable(fault_event))

endmodule

bind timer_progress_monitor_unit tpm_checker u_tpm_checker (.*);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Timer progress monitor testbench
// Feeds counter samples through the valid/stall input and scores every result
// against a cycle-free model of the wrap delta, the debounce runs and the
// latched health. It walks through several register settings between phases
// and ends with a phase that latches one fault.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import tpm_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1750;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned QUIET_FROM   = 700;
	localparam int unsigned QUIET_TO     = 1000;
	localparam int unsigned SETTLE_WAIT  = 4;

	typedef enum logic [1:0] {STEP_GOOD, STEP_STUCK, STEP_DRIFT} step_kind_t;

	typedef enum logic [1:0] {
		PHASE_SHAPED,
		PHASE_FULL_WINDOW,
		PHASE_EXTREME,
		PHASE_DISABLED
	} phase_kind_t;

	typedef struct packed {
		health_t     health;
		logic [63:0] elapsed;
		logic        checked;
		logic        fault_event;
	} health_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [63:0] counter_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [1:0] health;
	logic [63:0] elapsed;
	logic checked;
	logic fault_event;

	timer_progress_monitor_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.counter_value(counter_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.health       (health),
		.elapsed      (elapsed),
		.checked      (checked),
		.fault_event  (fault_event)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Register copy shared by the model and the sample generator.
	tpm_cfg_t cfg = '{
		monitor_enable: 1'b1, counter_is_wide: 1'b0, lower_limit: 64'd0,
		upper_limit: ALL_ONES_64, debounce_limit: DEBOUNCE_RESET,
		startup_wait: STARTUP_RESET, report_enable: 1'b1
	};

	// Model state.
	logic [63:0] last_sample = '0;
	logic [31:0] periods_seen = '0;
	logic [7:0]  stuck_count = '0;
	logic [7:0]  drift_count = '0;
	health_t     health_now = HEALTH_START;
	logic [63:0] last_elapsed = '0;

	// Generator view of the sample stream. bad_streak is an upper bound on both
	// debounce runs, so the generator can keep them below the limit.
	logic [63:0] gen_prev = '0;
	int unsigned gen_period = 0;
	int          bad_streak = 0;

	logic [63:0]    pending_samples[$];
	health_report_t pending_health[$];
	int unsigned    samples_queued = 0;
	int unsigned    samples_taken = 0;
	int unsigned    results_seen = 0;
	int unsigned    mismatch_count = 0;
	int unsigned    cycle_count = 0;
	logic           sample_taken = 1'b0;

	function automatic logic [63:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] pick_between(input logic [63:0] lo, input logic [63:0] hi);
		if (hi - lo == ALL_ONES_64)
			return random_word();
		return lo + random_word() % (hi - lo + 64'd1);
	endfunction

	function automatic bit take_break(input int unsigned progress);
		if (progress >= QUIET_FROM && progress < QUIET_TO)
			return 1'b0;
		return $urandom_range(0, 99) < 23;
	endfunction

	// Wrap-tolerant distance; one count short of the true distance on wrap.
	function automatic logic [63:0] wrap_delta(input logic [63:0] prev, input logic [63:0] cur);
		if (cur < prev)
			return (cfg.counter_is_wide ? ALL_ONES_64 : ALL_ONES_32) - prev + cur;
		return cur - prev;
	endfunction

	function automatic step_kind_t classify_step(input logic [63:0] prev,
			input logic [63:0] cur);
		logic [63:0] delta;
		delta = wrap_delta(prev, cur);
		if (cur == prev)
			return STEP_STUCK;
		if (delta < cfg.lower_limit || delta > cfg.upper_limit)
			return STEP_DRIFT;
		return STEP_GOOD;
	endfunction

	// Finds a next sample whose wrap delta from gen_prev equals d, trying the
	// plain sum and the wrapped forms of both counter widths.
	function automatic logic [63:0] step_from(input logic [63:0] d, input step_kind_t want);
		logic [63:0] cand[4];
		cand[0] = gen_prev + d;
		cand[1] = gen_prev + d + 64'd1;
		cand[2] = gen_prev + d - ALL_ONES_32;
		cand[3] = (gen_prev + d + 64'd1) & ALL_ONES_32;
		for (int i = 0; i < 4; i++) begin
			if (classify_step(gen_prev, cand[i]) == want)
				return cand[i];
		end
		return cand[0];
	endfunction

	function automatic logic [63:0] next_sample(input phase_kind_t kind);
		int unsigned roll;
		logic [63:0] d;
		roll = $urandom_range(0, 99);
		if (bad_streak + 2 >= int'(cfg.debounce_limit))
			roll = 0;
		case (kind)
			PHASE_DISABLED: begin
				return (roll < 80) ? random_word() : gen_prev;
			end
			PHASE_FULL_WINDOW: begin
				return (roll < 85) ? random_word() : gen_prev;
			end
			PHASE_EXTREME: begin
				return (roll < 80) ? step_from(64'($urandom_range(0, 64)), STEP_DRIFT)
					: random_word();
			end
			default: begin
				if (roll < 78)
					return step_from(pick_between(cfg.lower_limit, cfg.upper_limit),
						STEP_GOOD);
				if (roll < 86)
					return gen_prev;
				if (roll < 94) begin
					if (cfg.lower_limit > 64'd1 && $urandom_range(0, 1))
						d = pick_between(64'd1, cfg.lower_limit - 64'd1);
					else
						d = cfg.upper_limit + 64'd1 + 64'($urandom_range(0, 999));
					return step_from(d, STEP_DRIFT);
				end
				return random_word();
			end
		endcase
	endfunction

	task automatic queue_sample(input logic [63:0] cur);
		if (cfg.monitor_enable) begin
			if (classify_step(gen_prev, cur) != STEP_GOOD)
				bad_streak++;
			else if (64'(gen_period) >= 64'(cfg.startup_wait))
				bad_streak = 0;
			gen_prev = cur;
		end
		gen_period++;
		pending_samples.push_back(cur);
		samples_queued++;
	endtask

	task automatic predict_health(input logic [63:0] cur);
		health_report_t r;
		r.checked = 1'b0;
		r.fault_event = 1'b0;
		if (cfg.monitor_enable) begin
			if (periods_seen >= cfg.startup_wait && health_now != HEALTH_STUCK &&
					health_now != HEALTH_DRIFT) begin
				last_elapsed = wrap_delta(last_sample, cur);
				r.checked = 1'b1;
				case (classify_step(last_sample, cur))
					STEP_STUCK: if (stuck_count != RUN_MAX) stuck_count++;
					STEP_DRIFT: if (drift_count != RUN_MAX) drift_count++;
					default: begin
						stuck_count = '0;
						drift_count = '0;
					end
				endcase
				// Stuck wins when both runs are at the limit.
				if (stuck_count >= cfg.debounce_limit)
					health_now = HEALTH_STUCK;
				else if (drift_count >= cfg.debounce_limit)
					health_now = HEALTH_DRIFT;
				else
					health_now = HEALTH_OK;
				r.fault_event = (health_now == HEALTH_STUCK || health_now == HEALTH_DRIFT) &&
					cfg.report_enable;
			end
			last_sample = cur;
		end
		// The period count advances on every sample, enabled or not, until it saturates.
		if (periods_seen != '1)
			periods_seen++;
		r.health = health_now;
		r.elapsed = last_elapsed;
		pending_health.push_back(r);
	endtask

	// Sample driver: a stalled transaction holds its payload.
	always @(negedge clk) begin
		if (arst_n && (!sample_valid || sample_taken)) begin
			if (pending_samples.size() != 0 && !take_break(samples_taken)) begin
				sample_valid <= 1'b1;
				counter_value <= pending_samples.pop_front();
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		result_stall <= take_break(results_seen);
	end

	always @(posedge clk) begin
		health_report_t want;
		sample_taken <= sample_valid && !sample_stall;
		if (arst_n && sample_valid && !sample_stall) begin
			predict_health(counter_value);
			samples_taken++;
		end
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_health.size() == 0) begin
				if (mismatch_count < 10)
					$display("result %0d arrived with no sample pending: health %0d elapsed %h",
						results_seen, health, elapsed);
				mismatch_count++;
			end else begin
				want = pending_health.pop_front();
				if (health !== want.health || elapsed !== want.elapsed ||
						checked !== want.checked || fault_event !== want.fault_event) begin
					if (mismatch_count < 10) begin
						$display("result %0d mismatch: expected health %0d elapsed %h checked %b event %b",
							results_seen, want.health, want.elapsed, want.checked,
							want.fault_event);
						$display("  actual health %0d elapsed %h checked %b event %b",
							health, elapsed, checked, fault_event);
					end
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Waits until every queued sample is taken and every result is back.
	task automatic settle();
		while (samples_taken != samples_queued || pending_health.size() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_MONITOR_ENABLE:  cfg.monitor_enable = value[0];
			REG_COUNTER_IS_WIDE: cfg.counter_is_wide = value[0];
			REG_LOWER_LIMIT:     cfg.lower_limit = value;
			REG_UPPER_LIMIT:     cfg.upper_limit = value;
			REG_DEBOUNCE_LIMIT:  cfg.debounce_limit = value[7:0];
			REG_STARTUP_WAIT:    cfg.startup_wait = value[31:0];
			REG_REPORT_ENABLE:   cfg.report_enable = value[0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input tpm_cfg_t c);
		settle();
		write_reg(REG_MONITOR_ENABLE, 64'(c.monitor_enable));
		write_reg(REG_COUNTER_IS_WIDE, 64'(c.counter_is_wide));
		write_reg(REG_LOWER_LIMIT, c.lower_limit);
		write_reg(REG_UPPER_LIMIT, c.upper_limit);
		write_reg(REG_DEBOUNCE_LIMIT, 64'(c.debounce_limit));
		write_reg(REG_STARTUP_WAIT, 64'(c.startup_wait));
		write_reg(REG_REPORT_ENABLE, 64'(c.report_enable));
	endtask

	task automatic run_phase(input phase_kind_t kind);
		tpm_cfg_t c;
		int unsigned count;
		int unsigned db_low;
		int unsigned db_high;
		int unsigned roll;
		c = cfg;
		c.monitor_enable = 1'b1;
		c.counter_is_wide = 1'($urandom_range(0, 1));
		c.report_enable = 1'($urandom_range(0, 1));
		c.debounce_limit = RUN_MAX;
		c.startup_wait = '0;
		case (kind)
			PHASE_DISABLED: begin
				c = cfg;
				c.monitor_enable = 1'b0;
				c.counter_is_wide = 1'($urandom_range(0, 1));
				count = $urandom_range(20, 40);
			end
			PHASE_FULL_WINDOW: begin
				c.lower_limit = '0;
				c.upper_limit = ALL_ONES_64;
				count = $urandom_range(50, 100);
			end
			PHASE_EXTREME: begin
				roll = $urandom_range(0, 2);
				if (roll == 0) begin
					// Inverted window: every changing sample is drift.
					c.lower_limit = 64'($urandom_range(100, 5000));
					c.upper_limit = c.lower_limit - 64'($urandom_range(1, 99));
				end else begin
					c.lower_limit = (roll == 1) ? ALL_ONES_64 : 64'd0;
					c.upper_limit = c.lower_limit;
				end
				count = (bad_streak >= 220) ? 0 : $urandom_range(10, 30);
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					c.lower_limit = 64'($urandom_range(1, 20));
					c.upper_limit = c.lower_limit + 64'($urandom_range(0, 300));
				end else if (c.counter_is_wide) begin
					c.lower_limit = (random_word() >> $urandom_range(2, 40)) | 64'd1;
					c.upper_limit = c.lower_limit + (random_word() >> $urandom_range(2, 40));
				end else begin
					c.lower_limit = 64'(($urandom() >> $urandom_range(2, 20)) | 1);
					c.upper_limit = c.lower_limit + 64'($urandom() >> $urandom_range(2, 20));
				end
				db_low = bad_streak + 8;
				if (db_low > 255)
					db_low = 255;
				db_high = (db_low + 20 > 255 || $urandom_range(0, 1)) ? 255 : db_low + 20;
				c.debounce_limit = 8'($urandom_range(db_low, db_high));
				roll = $urandom_range(0, 99);
				if (roll < 50)
					c.startup_wait = '0;
				else if (roll < 75)
					c.startup_wait = 32'($urandom_range(0, gen_period));
				else if (roll < 90)
					c.startup_wait = 32'(gen_period + $urandom_range(1, 60));
				else
					c.startup_wait = '1;
				count = $urandom_range(60, 150);
			end
		endcase
		apply_config(c);
		repeat (count) queue_sample(next_sample(kind));
	endtask

	initial begin
		tpm_cfg_t c;
		int unsigned mode;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: these fall inside the start-up wait.
		queue_sample(64'd0);
		queue_sample(ALL_ONES_64);
		queue_sample(64'h5555_5555_5555_5555);
		queue_sample(64'hAAAA_AAAA_AAAA_AAAA);

		c = cfg;
		c.startup_wait = '0;
		c.lower_limit = 64'd1;
		c.upper_limit = 64'd1000;
		apply_config(c);
		queue_sample(64'd10);
		queue_sample(64'd10);
		queue_sample(64'd110);
		queue_sample(64'hFFFF_FFF0);
		// 32-bit wrap, then a repeat and a one-count step.
		queue_sample(64'd5);
		queue_sample(64'd5);
		queue_sample(64'd6);

		c.counter_is_wide = 1'b1;
		apply_config(c);
		queue_sample(ALL_ONES_64 - 64'd5);
		queue_sample(64'd3);
		queue_sample(64'd1003);
		queue_sample(64'd2004);
		queue_sample(64'd2005);

		c.monitor_enable = 1'b0;
		apply_config(c);
		queue_sample(64'd7);
		queue_sample(64'd7);
		c.monitor_enable = 1'b1;
		apply_config(c);
		queue_sample(64'd2010);

		while (samples_queued < RANDOM_ITEMS + 19) begin
			case ($urandom_range(0, 9))
				0: run_phase(PHASE_DISABLED);
				1: run_phase(PHASE_EXTREME);
				2, 3: run_phase(PHASE_FULL_WINDOW);
				default: run_phase(PHASE_SHAPED);
			endcase
		end

		// Last phase: latch one fault, then show that it holds.
		c = cfg;
		c.monitor_enable = 1'b1;
		c.counter_is_wide = 1'($urandom_range(0, 1));
		c.startup_wait = '0;
		c.lower_limit = 64'd1;
		c.upper_limit = 64'd100;
		c.debounce_limit = RUN_MAX;
		c.report_enable = 1'($urandom_range(0, 1));
		apply_config(c);
		queue_sample(step_from(64'd50, STEP_GOOD));
		mode = $urandom_range(0, 3);
		if (mode == 3) begin
			// Build both runs up, then lower the limit under them.
			repeat (4) begin
				queue_sample(gen_prev);
				queue_sample(step_from(64'd500, STEP_DRIFT));
			end
			c.debounce_limit = 8'd4;
			apply_config(c);
			queue_sample(step_from(64'd500, STEP_DRIFT));
		end else begin
			c.debounce_limit = (mode == 0) ? 8'd0 : 8'($urandom_range(1, 6));
			apply_config(c);
			repeat (8)
				queue_sample((mode == 2) ? step_from(64'd500, STEP_DRIFT) : gen_prev);
		end
		repeat (15) queue_sample(random_word());

		settle();
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
